// ===== rtl/balanced_split_plane_search_unit_defines.svh =====
// ============================================================================
// Balanced split plane search: assertion macros
// Shared property forms for the concurrent checks of the search unit.
// ============================================================================
`ifndef BALANCED_SPLIT_PLANE_SEARCH_UNIT_DEFINES_SVH
`define BALANCED_SPLIT_PLANE_SEARCH_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSPSU_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSPSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bspsu_pkg.sv =====
// ============================================================================
// Balanced split plane search: package
// Shared widths, defaults, sequencer states and the tally control word.
// ============================================================================
`timescale 1ns / 1ps

package bspsu_pkg;

    // Coordinate width of one interval bound.
    localparam int COORD_W = 32;
    // Width of the count fields in a result word.
    localparam int FIELD_CNT_W = 11;
    // Default storage depth in intervals.
    localparam int BSPSU_MAX_INTERVALS = 1024;
    // Reset value of the split threshold register.
    localparam logic [FIELD_CNT_W-1:0] TARGET_RESET = 11'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_CAND,
        ST_SWEEP,
        ST_DRAIN,
        ST_DECIDE,
        ST_FINISH
    } bspsu_state_t;

    // Control word from the sequencer to the tally unit.
    typedef struct packed {
        logic clear;
        logic sample;
    } bspsu_tally_ctl_t;

endpackage

// ===== rtl/bspsu_interval_mem.sv =====
// ============================================================================
// Balanced split plane search: interval memory
// Lower and upper bound arrays with one write port and one registered read.
// ============================================================================
`timescale 1ns / 1ps

module bspsu_interval_mem #(
    parameter int DEPTH = bspsu_pkg::BSPSU_MAX_INTERVALS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                               aclk,
    input  logic                               wr_en,
    input  logic [AW-1:0]                      wr_addr,
    input  logic signed [bspsu_pkg::COORD_W-1:0] wr_lo,
    input  logic signed [bspsu_pkg::COORD_W-1:0] wr_hi,
    input  logic                               rd_en,
    input  logic [AW-1:0]                      rd_addr,
    output logic signed [bspsu_pkg::COORD_W-1:0] rd_lo,
    output logic signed [bspsu_pkg::COORD_W-1:0] rd_hi
);
    import bspsu_pkg::*;

    logic signed [COORD_W-1:0] lower_mem [DEPTH];
    logic signed [COORD_W-1:0] upper_mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            lower_mem[wr_addr] <= wr_lo;
            upper_mem[wr_addr] <= wr_hi;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_lo <= lower_mem[rd_addr];
            rd_hi <= upper_mem[rd_addr];
        end
    end

endmodule

// ===== rtl/bspsu_tally.sv =====
// ============================================================================
// Balanced split plane search: tally unit
// Classifies one stored interval per cycle, while sample is set, against the
// current plane and keeps the front, back and straddle counts of the sweep.
// ============================================================================
`timescale 1ns / 1ps

module bspsu_tally #(
    parameter int CW = 11
) (
    input  logic                                 aclk,
    input  bspsu_pkg::bspsu_tally_ctl_t          ctl,
    input  logic signed [bspsu_pkg::COORD_W-1:0] plane,
    input  logic signed [bspsu_pkg::COORD_W-1:0] lo,
    input  logic signed [bspsu_pkg::COORD_W-1:0] hi,
    output logic [CW-1:0]                        front_cnt,
    output logic [CW-1:0]                        back_cnt,
    output logic [CW-1:0]                        strad_cnt
);
    import bspsu_pkg::*;

    logic [CW-1:0] front_reg, back_reg, strad_reg;
    logic          is_strad, is_back;

    // An interval straddles when it crosses the plane strictly or sits on it.
    always_comb begin
        is_strad = ((lo == plane) && (hi == plane)) || ((lo < plane) && (hi > plane));
        is_back  = !is_strad && (lo < plane);
    end

    // Counters are cleared before each sweep and advance on each valid word.
    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            front_reg <= '0;
            back_reg  <= '0;
            strad_reg <= '0;
        end else if (ctl.sample) begin
            if (is_strad) begin
                strad_reg <= strad_reg + CW'(1);
            end else if (is_back) begin
                back_reg <= back_reg + CW'(1);
            end else begin
                front_reg <= front_reg + CW'(1);
            end
        end
    end

    assign front_cnt = front_reg;
    assign back_cnt  = back_reg;
    assign strad_cnt = strad_reg;

endmodule

// ===== rtl/balanced_split_plane_search_unit.sv =====
// ============================================================================
// Balanced split plane search unit
// Collects one axis's intervals; above the threshold, tries every stored bound
// as a split plane and reports the plane with the most even front/back split.
// ============================================================================
//
//  Channel  Ports                                      Direction  Word
//  -------  -----------------------------------------  ---------  ----------------
//  s_       s_valid s_ready s_low_bound s_high_bound    in         one interval
//           s_last_item
//  m_       m_valid m_ready m_split_found m_best_plane  out        one result
//           m_imbalance m_front_total m_back_total
//           m_straddle_total m_overflowed
//  cfg_     cfg_valid cfg_ready cfg_data               in         split threshold
//
//  Intervals load at one word per cycle into the bound memory.
//  After the last word of a set, each stored interval is fetched as a candidate
//  and each of its distinct bounds is tried in a sweep over the whole set, with
//  the single memory read port feeding the tally one stored interval per cycle.
//  A set at or below the threshold goes straight to the finish state; the result
//  then waits in the output register and loading of the next set may begin.
//  Reset is synchronous and active low; the memory needs no clearing.
//  A held result stalls only the end of the next evaluation.
// ============================================================================
`timescale 1ns / 1ps
`include "balanced_split_plane_search_unit_defines.svh"

module balanced_split_plane_search_unit #(
    parameter int MAX_INTERVALS = bspsu_pkg::BSPSU_MAX_INTERVALS
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // Interval input
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [bspsu_pkg::COORD_W-1:0]     s_low_bound,
    input  logic signed [bspsu_pkg::COORD_W-1:0]     s_high_bound,
    input  logic                                     s_last_item,
    // Result output
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic                                     m_split_found,
    output logic signed [bspsu_pkg::COORD_W-1:0]     m_best_plane,
    output logic [bspsu_pkg::FIELD_CNT_W-1:0]        m_imbalance,
    output logic [bspsu_pkg::FIELD_CNT_W-1:0]        m_front_total,
    output logic [bspsu_pkg::FIELD_CNT_W-1:0]        m_back_total,
    output logic [bspsu_pkg::FIELD_CNT_W-1:0]        m_straddle_total,
    output logic                                     m_overflowed,
    // Threshold register write
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [bspsu_pkg::FIELD_CNT_W-1:0]        cfg_data
);
    import bspsu_pkg::*;

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int XW = CW + FIELD_CNT_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

    bspsu_state_t state_reg, state_next;

    logic [CW-1:0]          count_reg, count_next;
    logic                   overflow_reg, overflow_next;
    logic [FIELD_CNT_W-1:0] target_reg;
    logic [CW-1:0]          cand_idx_reg, cand_idx_next;
    logic [CW-1:0]          sweep_idx_reg, sweep_idx_next;
    logic                   phase_reg, phase_next;
    logic signed [COORD_W-1:0] cand_lo_reg, cand_lo_next;
    logic signed [COORD_W-1:0] cand_hi_reg, cand_hi_next;
    logic                   rd_valid_reg, rd_valid_next;

    logic                   found_reg, found_next;
    logic signed [COORD_W-1:0] best_plane_reg, best_plane_next;
    logic [CW-1:0]          best_bal_reg, best_bal_next;
    logic [CW-1:0]          best_front_reg, best_front_next;
    logic [CW-1:0]          best_back_reg, best_back_next;
    logic [CW-1:0]          best_strad_reg, best_strad_next;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_found_reg, m_found_next;
    logic signed [COORD_W-1:0] m_plane_reg, m_plane_next;
    logic [FIELD_CNT_W-1:0] m_bal_reg, m_bal_next;
    logic [FIELD_CNT_W-1:0] m_front_reg, m_front_next;
    logic [FIELD_CNT_W-1:0] m_back_reg, m_back_next;
    logic [FIELD_CNT_W-1:0] m_strad_reg, m_strad_next;
    logic                   m_ovf_reg, m_ovf_next;

    logic                   mem_wr_en, mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    logic signed [COORD_W-1:0] mem_rd_lo, mem_rd_hi;

    bspsu_tally_ctl_t       tally_ctl;
    logic signed [COORD_W-1:0] plane;
    logic [CW-1:0]          front_cnt, back_cnt, strad_cnt;

    logic                   has_room;
    logic [CW-1:0]          set_size;
    logic [CW-1:0]          bal;
    logic                   plane_ok, plane_better;
    logic [XW-1:0]          x_bal, x_front, x_back, x_strad;

    // Bound storage.
    bspsu_interval_mem #(
        .DEPTH (MAX_INTERVALS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_lo   (s_low_bound),
        .wr_hi   (s_high_bound),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_lo   (mem_rd_lo),
        .rd_hi   (mem_rd_hi)
    );

    // Classification counters for the plane under test.
    assign plane = phase_reg ? cand_hi_reg : cand_lo_reg;

    bspsu_tally #(
        .CW (CW)
    ) u_tally (
        .aclk      (aclk),
        .ctl       (tally_ctl),
        .plane     (plane),
        .lo        (mem_rd_lo),
        .hi        (mem_rd_hi),
        .front_cnt (front_cnt),
        .back_cnt  (back_cnt),
        .strad_cnt (strad_cnt)
    );

    // Plane scoring from the finished sweep.
    always_comb begin
        bal          = (back_cnt < front_cnt) ? (front_cnt - back_cnt)
                                              : (back_cnt - front_cnt);
        plane_ok     = (front_cnt != '0) && (back_cnt != '0);
        plane_better = plane_ok && (!found_reg || (bal < best_bal_reg));
    end

    // Count fields of a result are the low bits of the internal counts.
    always_comb begin
        x_bal   = XW'(best_bal_reg);
        x_front = XW'(best_front_reg);
        x_back  = XW'(best_back_reg);
        x_strad = XW'(best_strad_reg);
    end

    assign has_room = (count_reg < MAX_CNT);
    assign set_size = has_room ? (count_reg + CW'(1)) : count_reg;

    // Sequencer: next state, memory control and datapath updates.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        cand_idx_next   = cand_idx_reg;
        sweep_idx_next  = sweep_idx_reg;
        phase_next      = phase_reg;
        cand_lo_next    = cand_lo_reg;
        cand_hi_next    = cand_hi_reg;
        rd_valid_next   = (state_reg == ST_SWEEP);
        found_next      = found_reg;
        best_plane_next = best_plane_reg;
        best_bal_next   = best_bal_reg;
        best_front_next = best_front_reg;
        best_back_next  = best_back_reg;
        best_strad_next = best_strad_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_found_next    = m_found_reg;
        m_plane_next    = m_plane_reg;
        m_bal_next      = m_bal_reg;
        m_front_next    = m_front_reg;
        m_back_next     = m_back_reg;
        m_strad_next    = m_strad_reg;
        m_ovf_next      = m_ovf_reg;
        s_ready         = 1'b0;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = sweep_idx_reg[AW-1:0];
        tally_ctl       = '0;
        tally_ctl.sample = rd_valid_reg;

        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (has_room) begin
                        mem_wr_en  = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                    if (s_last_item) begin
                        found_next    = 1'b0;
                        cand_idx_next = '0;
                        if (XW'(set_size) > XW'(target_reg)) begin
                            state_next = ST_FETCH;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_FETCH: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = cand_idx_reg[AW-1:0];
                state_next  = ST_CAND;
            end
            ST_CAND: begin
                cand_lo_next    = mem_rd_lo;
                cand_hi_next    = mem_rd_hi;
                phase_next      = 1'b0;
                sweep_idx_next  = '0;
                tally_ctl.clear = 1'b1;
                state_next      = ST_SWEEP;
            end
            ST_SWEEP: begin
                mem_rd_en = 1'b1;
                if (sweep_idx_reg == count_reg - CW'(1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    sweep_idx_next = sweep_idx_reg + CW'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                tally_ctl.clear = 1'b1;
                if (plane_better) begin
                    found_next      = 1'b1;
                    best_plane_next = plane;
                    best_bal_next   = bal;
                    best_front_next = front_cnt;
                    best_back_next  = back_cnt;
                    best_strad_next = strad_cnt;
                end
                // The upper bound is tried next unless it equals the lower.
                if (!phase_reg && (cand_lo_reg != cand_hi_reg)) begin
                    phase_next     = 1'b1;
                    sweep_idx_next = '0;
                    state_next     = ST_SWEEP;
                end else if (cand_idx_reg == count_reg - CW'(1)) begin
                    state_next = ST_FINISH;
                end else begin
                    cand_idx_next = cand_idx_reg + CW'(1);
                    state_next    = ST_FETCH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = found_reg;
                    m_plane_next  = found_reg ? best_plane_reg : '0;
                    m_bal_next    = found_reg ? x_bal[FIELD_CNT_W-1:0] : '0;
                    m_front_next  = found_reg ? x_front[FIELD_CNT_W-1:0] : '0;
                    m_back_next   = found_reg ? x_back[FIELD_CNT_W-1:0] : '0;
                    m_strad_next  = found_reg ? x_strad[FIELD_CNT_W-1:0] : '0;
                    m_ovf_next    = overflow_reg;
                    count_next    = '0;
                    overflow_next = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            found_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            found_reg    <= found_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RESET;
        end else if (cfg_valid && cfg_ready) begin
            target_reg <= cfg_data;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        cand_idx_reg   <= cand_idx_next;
        sweep_idx_reg  <= sweep_idx_next;
        phase_reg      <= phase_next;
        cand_lo_reg    <= cand_lo_next;
        cand_hi_reg    <= cand_hi_next;
        best_plane_reg <= best_plane_next;
        best_bal_reg   <= best_bal_next;
        best_front_reg <= best_front_next;
        best_back_reg  <= best_back_next;
        best_strad_reg <= best_strad_next;
        m_found_reg    <= m_found_next;
        m_plane_reg    <= m_plane_next;
        m_bal_reg      <= m_bal_next;
        m_front_reg    <= m_front_next;
        m_back_reg     <= m_back_next;
        m_strad_reg    <= m_strad_next;
        m_ovf_reg      <= m_ovf_next;
    end

    // Output ports.
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_split_found    = m_found_reg;
    assign m_best_plane     = m_plane_reg;
    assign m_imbalance      = m_bal_reg;
    assign m_front_total    = m_front_reg;
    assign m_back_total     = m_back_reg;
    assign m_straddle_total = m_strad_reg;
    assign m_overflowed     = m_ovf_reg;

    // Checks on the sequencer and the kept plane.
    `BSPSU_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= MAX_CNT, "item count above storage depth")
    `BSPSU_ASSERT_SAME(a_cand_in_set, aclk, aresetn, (state_reg != ST_LOAD) && (state_reg != ST_FINISH), cand_idx_reg < count_reg, "candidate index outside stored set")
    `BSPSU_ASSERT_NEXT(a_kept_plane_splits, aclk, aresetn, (state_reg == ST_DECIDE) && plane_better, found_reg && (best_front_reg != '0) && (best_back_reg != '0), "kept plane does not split both sides")

endmodule
